// ----- rtl/fnb_pkg.sv -----
`default_nettype none

package fnb_pkg;

   // sequencer steps; each step but S_GS and S_MIX issues one product on the shared multiplier
   typedef enum logic [2:0] {
      S_IDLE,
      S_HP,
      S_KG,
      S_LP,
      S_GE,
      S_GS,
      S_AM,
      S_MIX
   } state_type;

   // envelope segment: rising ramp, falling ramp, flat top, silent
   typedef enum logic [1:0] {
      ENV_RISE,
      ENV_FALL,
      ENV_FULL,
      ENV_ZERO
   } env_kind_type;

   typedef struct packed {
      env_kind_type kind;
      logic [24:0]  op;
      logic [19:0]  recip;
   } env_plan_type;

   // register indexes
   localparam logic [2:0] CSR_HIGH_ALPHA   = 3'd0;
   localparam logic [2:0] CSR_LOW_ALPHA    = 3'd1;
   localparam logic [2:0] CSR_INTENSITY    = 3'd2;
   localparam logic [2:0] CSR_BURST_LENGTH = 3'd3;
   localparam logic [2:0] CSR_PHASE_STEP   = 3'd4;
   localparam logic [2:0] CSR_CRESCENDO    = 3'd5;

   localparam logic [31:0] NOISE_SEED    = 32'd2463534242;
   localparam logic [24:0] P055          = 25'd9227469;
   localparam logic [24:0] P008          = 25'd1342177;
   localparam logic [24:0] P092          = 25'd15434650;
   localparam logic [24:0] ONE_Q24       = 25'd16777216;
   localparam logic [19:0] INV055        = 20'd119156;
   localparam logic [19:0] INV045        = 20'd145636;
   localparam logic [19:0] INV008        = 20'd819200;
   localparam logic [14:0] K035          = 15'd22938;
   localparam logic [16:0] ENV_UNITY     = 17'd65536;
   localparam logic [15:0] INTENSITY_MIN = 16'd32;

   // pick segment, multiplier operand and reciprocal for a phase (Q0.24)
   function automatic env_plan_type env_plan(input logic [24:0] p, input logic cresc);
      env_plan_type r;
      r.kind  = ENV_FULL;
      r.op    = '0;
      r.recip = '0;
      if (cresc) begin
         if (p < P055) begin
            r.kind  = ENV_RISE;
            r.op    = p;
            r.recip = INV055;
         end else begin
            r.kind  = ENV_FALL;
            r.op    = p - P055;
            r.recip = INV045;
         end
      end else if (p < P008) begin
         r.kind  = ENV_RISE;
         r.op    = p;
         r.recip = INV008;
      end else if (p > P092) begin
         if (p >= ONE_Q24) begin
            r.kind = ENV_ZERO;
         end else begin
            r.kind  = ENV_RISE;
            r.op    = ONE_Q24 - p;
            r.recip = INV008;
         end
      end
      return r;
   endfunction

   // xorshift32, shifts 13, 17, 5
   function automatic logic [31:0] xorshift32(input logic [31:0] w);
      logic [31:0] a;
      logic [31:0] b;
      a = w ^ (w << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

   // saturate to signed 32 bits
   function automatic logic signed [31:0] clamp32(input logic signed [54:0] v);
      logic signed [31:0] r;
      if (v > 55'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -55'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/filtered_noise_burst.sv -----
// A word taken outside a burst goes from the idle step to the mix step and into the output
// register; inside a burst it passes the filter steps HP, KG, LP, GE, GS and AM in between;
// the idle step and all filter steps but GS issue a product on the shared 34x21 multiplier.
// A new word is taken only after the last one is in the output register: req_tready is high
// only while the sequencer is idle, and a finished result waits in the output register.
// Reset (synchronous, active high) clears registers to defaults, filters, index and phase,
// stops any burst and reloads the noise generator seed.
`default_nettype none

module filtered_noise_burst
   import fnb_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int INDEX_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // base_sample
   input  wire logic                                req_tuser,  // restart
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,  // mixed_sample
   output logic                                     rsp_tuser,  // burst_active
   output logic                                     rsp_tlast,  // burst_last
   // register writes
   input  wire logic                                csr_we,
   input  wire logic [2:0]                          csr_addr,
   input  wire logic [24:0]                         csr_wdata
);

   localparam int DataW    = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int MixShift = 45 - SAMPLE_BITS;
   localparam logic [31:0] IdxMax = 32'((64'd1 << INDEX_BITS) - 64'd1);
   localparam logic signed [55:0] SMax = (56'sd1 <<< (SAMPLE_BITS - 1)) - 56'sd1;
   localparam logic signed [55:0] SMin = -SMax - 56'sd1;
   localparam logic signed [54:0] MixHalf = 55'sd1 <<< (MixShift - 1);

   // configuration
   logic [15:0] high_alpha_ff;
   logic [15:0] low_alpha_ff;
   logic [15:0] intensity_ff;
   logic [15:0] burst_length_ff;
   logic [24:0] phase_step_ff;
   logic        crescendo_ff;

   // burst state
   state_type                state_ff, state_in;
   logic [31:0]              noise_ff;
   logic signed [31:0]       hpt_ff;
   logic signed [31:0]       lpt_ff;
   logic [INDEX_BITS-1:0]    idx_ff;
   logic [24:0]              phase_ff;
   logic                     running_ff;

   // per-word working registers
   logic signed [SAMPLE_BITS-1:0] base_ff;
   logic                          run_ff;
   logic signed [28:0]            white_ff;
   logic signed [54:0]            prod_ff;
   logic [16:0]                   env_ff;
   logic [15:0]                   gain_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] mixed_ff;
   logic                   active_ff;
   logic                   last_ff;

   // combinational
   logic                  accept;
   logic                  restart;
   logic [INDEX_BITS-1:0] len;
   logic [INDEX_BITS-1:0] idx_eff;
   logic [24:0]           phase_eff;
   logic                  run_go;
   env_plan_type          plan_in;
   env_plan_type          plan_now;
   logic [31:0]           noise_next;
   logic signed [33:0]    mul_a;
   logic signed [20:0]    mul_b;
   logic signed [54:0]    mul_p;
   logic                  prod_load;
   logic signed [54:0]    rnd15;
   logic signed [54:0]    rnd16;
   logic signed [54:0]    rnd24;
   logic signed [54:0]    rnd_mix;
   logic [22:0]           env_s;
   logic signed [24:0]    env_raw;
   logic [16:0]           env_val;
   logic signed [55:0]    mix_sum;
   logic [SAMPLE_BITS-1:0] mix_sat;
   logic                  out_free;
   logic                  mix_load;
   logic                  last_now;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         high_alpha_ff   <= 16'd655;
         low_alpha_ff    <= 16'd655;
         intensity_ff    <= '0;
         burst_length_ff <= '0;
         phase_step_ff   <= '0;
         crescendo_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_HIGH_ALPHA:   high_alpha_ff   <= csr_wdata[15:0];
            CSR_LOW_ALPHA:    low_alpha_ff    <= csr_wdata[15:0];
            CSR_INTENSITY:    intensity_ff    <= csr_wdata[15:0];
            CSR_BURST_LENGTH: burst_length_ff <= csr_wdata[15:0];
            CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata;
            CSR_CRESCENDO:    crescendo_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // burst decision at accept
   assign accept    = req_tvalid && req_tready;
   assign restart   = req_tuser;
   assign len       = ({16'd0, burst_length_ff} > IdxMax) ? '1 : INDEX_BITS'(burst_length_ff);
   assign idx_eff   = restart ? '0 : idx_ff;
   assign phase_eff = restart ? '0 : phase_ff;
   assign run_go    = (restart || running_ff) && (intensity_ff > INTENSITY_MIN) &&
                      (len != '0) && (idx_eff < len);
   assign plan_in   = env_plan(phase_eff, crescendo_ff);
   assign plan_now  = env_plan(phase_ff, crescendo_ff);
   assign noise_next = xorshift32(noise_ff);

   // shared multiplier
   assign mul_p = mul_a * mul_b;

   // rounded reductions of the last product
   assign rnd15   = (prod_ff + 55'sd16384) >>> 15;
   assign rnd16   = (prod_ff + 55'sd32768) >>> 16;
   assign rnd24   = (prod_ff + 55'sd8388608) >>> 24;
   assign rnd_mix = (prod_ff + MixHalf) >>> MixShift;

   // envelope from the ramp product
   assign env_s = rnd24[22:0];
   always_comb begin
      unique case (plan_now.kind)
         ENV_RISE: env_raw = $signed({2'b00, env_s});
         ENV_FALL: env_raw = 25'sd65536 - $signed({2'b00, env_s});
         ENV_FULL: env_raw = 25'sd65536;
         ENV_ZERO: env_raw = '0;
         default:  env_raw = '0;
      endcase
      if (env_raw < 25'sd0) begin
         env_val = '0;
      end else if (env_raw > 25'sd65536) begin
         env_val = ENV_UNITY;
      end else begin
         env_val = env_raw[16:0];
      end
   end

   // mix and saturate
   assign mix_sum = 56'(rnd_mix) + 56'(base_ff);
   always_comb begin
      if (mix_sum > SMax) begin
         mix_sat = SMax[SAMPLE_BITS-1:0];
      end else if (mix_sum < SMin) begin
         mix_sat = SMin[SAMPLE_BITS-1:0];
      end else begin
         mix_sat = mix_sum[SAMPLE_BITS-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign mix_load = (state_ff == S_MIX) && out_free;
   assign last_now = run_ff && (({1'b0, idx_ff} + (INDEX_BITS+1)'(1)) == {1'b0, len});

   // next state
   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = accept ? (run_go ? S_HP : S_MIX) : S_IDLE;
         S_HP:    state_in = S_KG;
         S_KG:    state_in = S_LP;
         S_LP:    state_in = S_GE;
         S_GE:    state_in = S_GS;
         S_GS:    state_in = S_AM;
         S_AM:    state_in = S_MIX;
         S_MIX:   state_in = out_free ? S_IDLE : S_MIX;
         default: state_in = S_IDLE;
      endcase
   end

   // multiplier operands per step
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      prod_load  = (state_ff != S_MIX);
      unique case (state_ff)
         S_IDLE: begin
            mul_a = {9'd0, plan_in.op};
            mul_b = {1'b0, plan_in.recip};
         end
         S_HP: begin
            mul_a = 34'(white_ff) - 34'(hpt_ff);
            mul_b = {5'd0, high_alpha_ff};
         end
         S_KG: begin
            mul_a = {18'd0, intensity_ff};
            mul_b = {6'd0, K035};
         end
         S_LP: begin
            mul_a = 34'(white_ff) - 34'(hpt_ff) - 34'(lpt_ff);
            mul_b = {5'd0, low_alpha_ff};
         end
         S_GE: begin
            mul_a = {17'd0, env_ff};
            mul_b = {5'd0, gain_ff};
         end
         S_AM: begin
            mul_a = 34'(lpt_ff);
            mul_b = {5'd0, gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         noise_ff     <= NOISE_SEED;
         hpt_ff       <= '0;
         lpt_ff       <= '0;
         idx_ff       <= '0;
         phase_ff     <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            running_ff <= run_go;
            if (restart) begin
               hpt_ff   <= '0;
               lpt_ff   <= '0;
               idx_ff   <= '0;
               phase_ff <= '0;
            end
            if (run_go) begin
               noise_ff <= noise_next;
            end
         end
         // filter tracks
         if (state_ff == S_KG) begin
            hpt_ff <= clamp32(55'(hpt_ff) + rnd16);
         end
         if (state_ff == S_GE) begin
            lpt_ff <= clamp32(55'(lpt_ff) + rnd16);
         end
         // advance the burst as the result enters the output register
         if (mix_load) begin
            rsp_valid_ff <= 1'b1;
            if (run_ff) begin
               idx_ff   <= idx_ff + INDEX_BITS'(1);
               phase_ff <= phase_ff + phase_step_ff;
               if (last_now) begin
                  running_ff <= 1'b0;
               end
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff  <= $signed(req_tdata[SAMPLE_BITS-1:0]);
         run_ff   <= run_go;
         white_ff <= $signed(noise_next[31:3]);
      end
      if (prod_load) begin
         prod_ff <= mul_p;
      end
      if (state_ff == S_HP) begin
         env_ff <= env_val;
      end
      if (state_ff == S_LP) begin
         gain_ff <= rnd15[15:0];
      end
      if (state_ff == S_GS) begin
         gain_ff <= rnd16[15:0];
      end
      if (mix_load) begin
         mixed_ff  <= run_ff ? mix_sat : base_ff;
         active_ff <= run_ff;
         last_ff   <= last_now;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DataW'(mixed_ff);
   assign rsp_tuser  = active_ff;
   assign rsp_tlast  = last_ff;

   // checks
   a_valid_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_MIX))
      else $error("result word raised outside the mix step");

   a_last_is_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("burst_last without burst_active");

   a_env_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_KG |-> env_ff <= ENV_UNITY)
      else $error("envelope above unity");

   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      mix_load && last_now |=> !running_ff)
      else $error("burst still running after its last word");

   a_pass_short: assert property (@(posedge clock) disable iff (reset)
      accept && !run_go |=> state_ff == S_MIX)
      else $error("pass-through word entered the filter steps");

endmodule

`default_nettype wire

// ----- tb/tb_filtered_noise_burst.sv -----
`timescale 1ns / 1ps

module tb_filtered_noise_burst
   import fnb_pkg::*;
();

   // one sample word as it leaves the block
   typedef struct packed {
      logic [23:0] sample;
      logic        active;
      logic        last;
   } mix_word_type;

   // one sample word waiting to be offered
   typedef struct packed {
      logic [23:0] sample;
      logic        restart;
   } base_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // base_sample
   logic        req_tuser = 1'b0; // restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // mixed_sample
   logic        rsp_tuser;        // burst_active
   logic        rsp_tlast;        // burst_last
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [24:0] csr_wdata = '0;

   filtered_noise_burst u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // register copies
   logic [15:0] high_alpha_q;
   logic [15:0] low_alpha_q;
   logic [15:0] intensity_q;
   logic [15:0] length_q;
   logic [24:0] phase_step_q;
   logic        crescendo_q;

   // burst state copies
   logic [31:0] noise_state;
   longint      hp_state;
   longint      lp_state;
   int          burst_pos;
   logic [24:0] env_phase;
   bit          burst_on;

   base_word_type pending_q[$];
   mix_word_type  mix_expect_q[$];
   base_word_type next_word;
   mix_word_type  want;
   int         words_in;
   int         words_out;
   int         err_count;
   int         tx_gap;
   int         rx_stall;
   bit         tx_steady;
   bit         rx_steady;
   logic       rx_hold = 1'b0;

   // product reduction: add half an LSB, shift toward minus infinity
   function automatic longint rnd_shift(input longint x, input int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint sat32(input longint v);
      longint r;
      r = v;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   // Q0.24 phase times Q16 reciprocal, rounded to Q0.16
   function automatic longint ramp(input longint p, input longint k);
      return (p * k + (longint'(1) << 23)) >>> 24;
   endfunction

   // envelope level, Q0.16, 0 .. 1
   function automatic longint env_level(input longint p);
      longint e;
      if (crescendo_q) begin
         if (p < longint'(P055)) e = ramp(p, longint'(INV055));
         else e = longint'(ENV_UNITY) - ramp(p - longint'(P055), longint'(INV045));
      end else if (p < longint'(P008)) begin
         e = ramp(p, longint'(INV008));
      end else if (p > longint'(P092)) begin
         if (p >= longint'(ONE_Q24)) e = 0;
         else e = ramp(longint'(ONE_Q24) - p, longint'(INV008));
      end else begin
         e = longint'(ENV_UNITY);
      end
      if (e < 0) e = 0;
      if (e > longint'(ENV_UNITY)) e = longint'(ENV_UNITY);
      return e;
   endfunction

   // expected mixed word for one accepted sample; advances the burst state
   function automatic mix_word_type mix_predict(input logic [23:0] smp, input logic rst);
      mix_word_type r;
      longint      base;
      longint      res;
      longint      white;
      longint      hp;
      longint      gain;
      logic [31:0] w;
      base = longint'($signed(smp));
      res = base;
      r.active = 1'b0;
      r.last = 1'b0;
      if (rst) begin
         burst_on = 1'b1;
         hp_state = 0;
         lp_state = 0;
         burst_pos = 0;
         env_phase = '0;
      end
      if (burst_on && (intensity_q <= INTENSITY_MIN || length_q == 16'd0 ||
                       burst_pos >= int'(length_q)))
         burst_on = 1'b0;
      if (burst_on) begin
         w = noise_state;
         w = w ^ (w << 13);
         w = w ^ (w >> 17);
         w = w ^ (w << 5);
         noise_state = w;
         white = longint'($signed(w));
         white = white >>> 3;
         hp_state = sat32(hp_state +
                          rnd_shift(longint'(high_alpha_q) * (white - hp_state), 16));
         hp = white - hp_state;
         lp_state = sat32(lp_state +
                          rnd_shift(longint'(low_alpha_q) * (hp - lp_state), 16));
         gain = rnd_shift(longint'(intensity_q) * longint'(K035), 15);
         gain = rnd_shift(gain * env_level(longint'(env_phase)), 16);
         res = base + rnd_shift(lp_state * gain, 21);
         if (res > 64'sd8388607) res = 64'sd8388607;
         if (res < -64'sd8388608) res = -64'sd8388608;
         r.active = 1'b1;
         r.last = (burst_pos + 1 == int'(length_q));
         burst_pos = (burst_pos + 1) & 32'hFFFF;
         env_phase = env_phase + phase_step_q;
         if (r.last) burst_on = 1'b0;
      end
      r.sample = res[23:0];
      return r;
   endfunction

   // driver: offers queued words, with a random gap after each unless tx_steady is set
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            mix_expect_q.push_back(mix_predict(req_tdata, req_tuser));
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               next_word = pending_q.pop_front();
               req_tdata <= next_word.sample;
               req_tuser <= next_word.restart;
               req_tvalid <= 1'b1;
               tx_gap = tx_steady ? 0 : $urandom_range(0, 16);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: takes result words with random stalls and checks them
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (mix_expect_q.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("result word with nothing expected: %h active %b last %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = mix_expect_q.pop_front();
               words_out++;
               if (rsp_tdata !== want.sample || rsp_tuser !== want.active ||
                   rsp_tlast !== want.last) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("mismatch on word %0d: expected %h/%b/%b, got %h/%b/%b",
                              words_out, want.sample, want.active, want.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
            rx_stall = rx_steady ? 0 : $urandom_range(0, 16);
         end else if (rx_stall > 0) begin
            rx_stall--;
         end
         rsp_tready <= (rx_stall == 0) && !rx_hold;
      end
   end

   // register write while the block is idle; copy kept in step
   task automatic write_reg(input logic [2:0] idx, input logic [24:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HIGH_ALPHA:   high_alpha_q = val[15:0];
         CSR_LOW_ALPHA:    low_alpha_q = val[15:0];
         CSR_INTENSITY:    intensity_q = val[15:0];
         CSR_BURST_LENGTH: length_q = val[15:0];
         CSR_PHASE_STEP:   phase_step_q = val;
         CSR_CRESCENDO:    crescendo_q = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_word(input logic [23:0] smp, input logic rst);
      base_word_type b;
      b.sample = smp;
      b.restart = rst;
      pending_q.push_back(b);
      words_in++;
   endtask

   // all words back, then margin for the sequencer to settle
   task automatic wait_idle();
      while (words_out != words_in) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_alpha();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd65535;
         2: return 16'd655;
         3: return 16'd64880;
         default: return 16'($urandom_range(655, 64880));
      endcase
   endfunction

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic random_config(input bit all_regs);
      logic [15:0] len;
      logic [15:0] loud;
      logic [24:0] step;
      if (all_regs || $urandom_range(0, 1)) write_reg(CSR_HIGH_ALPHA, 25'(pick_alpha()));
      if (all_regs || $urandom_range(0, 1)) write_reg(CSR_LOW_ALPHA, 25'(pick_alpha()));
      if (all_regs || $urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 19))
            0: loud = 16'd0;
            1: loud = INTENSITY_MIN;
            2: loud = 16'd33;
            3: loud = 16'd65535;
            4: loud = 16'($urandom());
            default: loud = 16'($urandom_range(33, 32768));
         endcase
         write_reg(CSR_INTENSITY, 25'(loud));
      end
      if (all_regs || $urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 19))
            0: len = 16'd0;
            1: len = 16'd1;
            2: len = 16'd65535;
            3: len = 16'($urandom());
            default: len = 16'($urandom_range(2, 48));
         endcase
         case ($urandom_range(0, 11))
            0: step = '0;
            1: step = 25'h1FFFFFF;
            2: step = 25'($urandom());
            3: step = ONE_Q24;
            default: step = (len == 0) ? '0 : 25'((32'd16777216 + len / 2) / len);
         endcase
         write_reg(CSR_BURST_LENGTH, 25'(len));
         write_reg(CSR_PHASE_STEP, step);
      end
      if (all_regs || $urandom_range(0, 1)) write_reg(CSR_CRESCENDO, 25'($urandom_range(0, 1)));
   endtask

   // stimulus
   initial begin
      int n;
      int phase_no;
      high_alpha_q = 16'd655;
      low_alpha_q = 16'd655;
      intensity_q = '0;
      length_q = '0;
      phase_step_q = '0;
      crescendo_q = 1'b0;
      noise_state = NOISE_SEED;
      hp_state = 0;
      lp_state = 0;
      burst_pos = 0;
      env_phase = '0;
      burst_on = 1'b0;
      words_in = 0;
      words_out = 0;
      err_count = 0;
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // envelope at zero on the first word and flat after, plain high-pass, widest low-pass; sample extremes
      write_reg(CSR_HIGH_ALPHA, 25'd0);
      write_reg(CSR_LOW_ALPHA, 25'd65535);
      write_reg(CSR_INTENSITY, 25'd32768);
      write_reg(CSR_BURST_LENGTH, 25'd4);
      write_reg(CSR_PHASE_STEP, 25'd4194304);
      write_reg(CSR_CRESCENDO, 25'd0);
      push_word(24'h7FFFFF, 1'b1);
      push_word(24'h800000, 1'b0);
      push_word(24'h000000, 1'b0);
      push_word(24'hFFFFFF, 1'b0);
      push_word(24'h123456, 1'b0);   // after the burst: passes through
      wait_idle();

      // crescendo, phase running past one, restart in mid-burst
      write_reg(CSR_CRESCENDO, 25'd1);
      write_reg(CSR_BURST_LENGTH, 25'd3);
      write_reg(CSR_PHASE_STEP, 25'h1FFFFFF);
      write_reg(CSR_HIGH_ALPHA, 25'd64880);
      write_reg(CSR_LOW_ALPHA, 25'd655);
      push_word(24'h7FFFF0, 1'b1);
      push_word(24'h800010, 1'b0);
      push_word(24'h400000, 1'b1);
      push_word(24'hC00000, 1'b0);
      push_word(24'h000001, 1'b0);
      wait_idle();

      // one-sample burst
      write_reg(CSR_BURST_LENGTH, 25'd1);
      push_word(24'h7FFFFF, 1'b1);
      push_word(24'h7FFFFF, 1'b0);
      wait_idle();

      // burst left running, then intensity dropped to the floor
      write_reg(CSR_CRESCENDO, 25'd0);
      write_reg(CSR_BURST_LENGTH, 25'd20);
      write_reg(CSR_PHASE_STEP, 25'd838861);
      write_reg(CSR_INTENSITY, 25'd65535);
      push_word(24'h000000, 1'b1);
      push_word(24'h7FFFFF, 1'b0);
      push_word(24'h800000, 1'b0);
      push_word(24'h0FFFFF, 1'b0);
      wait_idle();
      write_reg(CSR_INTENSITY, 25'(INTENSITY_MIN));
      push_word(24'h555555, 1'b0);
      wait_idle();

      // burst left running, then length lowered below the index
      write_reg(CSR_INTENSITY, 25'd32768);
      push_word(24'hAAAAAA, 1'b1);
      push_word(24'h7FFFFF, 1'b0);
      push_word(24'h800000, 1'b0);
      wait_idle();
      write_reg(CSR_BURST_LENGTH, 25'd2);
      push_word(24'h333333, 1'b0);
      wait_idle();

      // random phases: mostly bursts opened by a restart, random content
      phase_no = 0;
      while (words_in < 1220) begin
         random_config(phase_no == 0);
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         n = $urandom_range(15, 60);
         for (int k = 0; k < n; k++) begin
            if (k == 0) push_word(pick_sample(), $urandom_range(0, 9) != 0);
            else push_word(pick_sample(), $urandom_range(0, 11) == 0);
         end
         // receiver holds off while the sender keeps offering
         if (phase_no == 4 || phase_no == 15) begin
            rx_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rx_hold <= 1'b0;
         end
         wait_idle();
         phase_no++;
      end

      if (err_count == 0 && mix_expect_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/fnb_pkg.sv
rtl/filtered_noise_burst.sv
tb/tb_filtered_noise_burst.sv
